/* sv/line_bresenham_rasterizer_macros.svh */
// Assertion macros used by the rasterizer top level.
`ifndef LINE_BRESENHAM_RASTERIZER_MACROS_SVH
`define LINE_BRESENHAM_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lbr_pkg.sv */
// Shared constants and types for the Bresenham line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  localparam int COORD_BITS  = 6;
  // error term spans roughly -2*major .. 2*minor
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // one classified line command
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    logic   sx_neg;
    logic   sy_neg;
    logic   y_major;
    coord_t major;
    err_t   err0;
    err_t   err_inc;  // 2*minor
    err_t   err_dec;  // 2*minor - 2*major
  } cmd_t;

  // back end to queue handshake and status
  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

endpackage

`default_nettype wire

/* sv/line_bresenham_rasterizer.sv */
// Top level of the Bresenham line rasterizer: front end, command queue, back end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   in       | in_valid / in_ready  | x_start, y_start, x_end, y_end
//   out      | out_valid / out_ready| pixel_x, pixel_y, is_last
//
// A line of major extent N emits N+1 pixels, one per cycle from the back-end
// stepper while out_ready lets it, after the stepper loads the command.
// Commands are accepted into a two-entry queue whenever it has room, so the
// front keeps taking beats while the back end draws or waits on out_ready.
// Reset (rst, synchronous) empties the queue and drops any line in progress.
// When out_ready is low the held pixel stays put and the stepper pauses.
`timescale 1ns / 1ps
`default_nettype none
`include "line_bresenham_rasterizer_macros.svh"

module line_bresenham_rasterizer (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire lbr_pkg::coord_t x_start,
  input  wire lbr_pkg::coord_t y_start,
  input  wire lbr_pkg::coord_t x_end,
  input  wire lbr_pkg::coord_t y_end,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lbr_pkg::coord_t      pixel_x,
  output lbr_pkg::coord_t      pixel_y,
  output logic                 is_last
);
  import lbr_pkg::*;

  cmd_t      front_cmd;
  cmd_t      q_head;
  logic      q_valid;
  logic      push;
  back_ctl_t back_ctl;

  assign push = in_valid && in_ready;

  lbr_front u_front (
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .cmd     (front_cmd)
  );

  lbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .not_full  (in_ready),
    .pop       (back_ctl.pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  lbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .ctl       (back_ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .is_last   (is_last)
  );

  `LBR_ASSERT_SAME(a_pop_only_idle, back_ctl.pop, q_valid && !back_ctl.busy, "pop while busy or empty")
  `LBR_ASSERT_NEXT(a_pop_starts_line, back_ctl.pop, back_ctl.busy, "line not started after pop")
  `LBR_ASSERT_NEXT(a_push_fills, push, q_valid, "queue empty after push")

endmodule

`default_nettype wire

/* sv/lbr_front.sv */
// Front end: turns a line command into step directions, major axis and error terms.
`timescale 1ns / 1ps
`default_nettype none

module lbr_front (
  input  wire lbr_pkg::coord_t x_start,
  input  wire lbr_pkg::coord_t y_start,
  input  wire lbr_pkg::coord_t x_end,
  input  wire lbr_pkg::coord_t y_end,
  output lbr_pkg::cmd_t        cmd
);
  import lbr_pkg::*;

  logic [COORD_BITS:0] ddx;
  logic [COORD_BITS:0] ddy;
  logic [COORD_BITS:0] ndx;
  logic [COORD_BITS:0] ndy;
  coord_t              adx;
  coord_t              ady;
  logic                y_major;
  coord_t              major;
  coord_t              minor;
  err_t                two_minor;
  err_t                two_major;

  assign ddx = {1'b0, x_end} - {1'b0, x_start};
  assign ddy = {1'b0, y_end} - {1'b0, y_start};
  assign ndx = -ddx;
  assign ndy = -ddy;
  assign adx = ddx[COORD_BITS] ? ndx[COORD_BITS-1:0] : ddx[COORD_BITS-1:0];
  assign ady = ddy[COORD_BITS] ? ndy[COORD_BITS-1:0] : ddy[COORD_BITS-1:0];

  // ties go to the x axis
  assign y_major = ady > adx;
  assign major   = y_major ? ady : adx;
  assign minor   = y_major ? adx : ady;

  assign two_minor = {1'b0, minor, 1'b0};
  assign two_major = {1'b0, major, 1'b0};

  always_comb begin
    cmd.x0      = x_start;
    cmd.y0      = y_start;
    cmd.sx_neg  = ddx[COORD_BITS];
    cmd.sy_neg  = ddy[COORD_BITS];
    cmd.y_major = y_major;
    cmd.major   = major;
    cmd.err0    = two_minor - {2'b00, major};
    cmd.err_inc = two_minor;
    cmd.err_dec = two_minor - two_major;
  end

endmodule

`default_nettype wire

/* sv/lbr_queue.sv */
// Short command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module lbr_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire lbr_pkg::cmd_t push_cmd,
  output logic               not_full,
  input  wire                pop,
  output logic               not_empty,
  output lbr_pkg::cmd_t      head
);
  import lbr_pkg::*;

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign not_full  = count != QCNT_BITS'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

/* sv/lbr_back.sv */
// Back end: walks one line a pixel per cycle into an output register, pausing while a held pixel waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module lbr_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_valid,
  input  wire lbr_pkg::cmd_t   q_cmd,
  output lbr_pkg::back_ctl_t   ctl,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lbr_pkg::coord_t      pixel_x,
  output lbr_pkg::coord_t      pixel_y,
  output logic                 is_last
);
  import lbr_pkg::*;

  logic   active;
  coord_t cur_x;
  coord_t cur_y;
  coord_t remaining;
  err_t   err;
  err_t   err_inc;
  err_t   err_dec;
  logic   sx_neg;
  logic   sy_neg;
  logic   y_major;

  logic   load;
  logic   emit;
  logic   step_minor;
  coord_t x_step;
  coord_t y_step;

  assign load       = !active && q_valid;
  assign emit       = active && (!out_valid || out_ready);
  assign step_minor = err > 0;
  assign x_step     = sx_neg ? cur_x - 1'b1 : cur_x + 1'b1;
  assign y_step     = sy_neg ? cur_y - 1'b1 : cur_y + 1'b1;

  assign ctl.pop  = load;
  assign ctl.busy = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end else if (emit && remaining == '0) begin
        active <= 1'b0;
      end
      // a new pixel refills the register, else a taken beat empties it
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x     <= q_cmd.x0;
      cur_y     <= q_cmd.y0;
      remaining <= q_cmd.major;
      err       <= q_cmd.err0;
      err_inc   <= q_cmd.err_inc;
      err_dec   <= q_cmd.err_dec;
      sx_neg    <= q_cmd.sx_neg;
      sy_neg    <= q_cmd.sy_neg;
      y_major   <= q_cmd.y_major;
    end else if (emit) begin
      pixel_x   <= cur_x;
      pixel_y   <= cur_y;
      is_last   <= remaining == '0;
      remaining <= remaining - 1'b1;
      err       <= step_minor ? err + err_dec : err + err_inc;
      if (y_major) begin
        cur_y <= y_step;
        if (step_minor) cur_x <= x_step;
      end else begin
        cur_x <= x_step;
        if (step_minor) cur_y <= y_step;
      end
    end
  end

endmodule

`default_nettype wire
